>>> hdl/table_interpolating_linearizer_unit_assert.svh
// Assertion macros for the table interpolating linearizer.
// Included by the top level; depends on nothing else.
`ifndef TABLE_INTERPOLATING_LINEARIZER_UNIT_ASSERT_SVH
`define TABLE_INTERPOLATING_LINEARIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TILU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TILU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tilu_pkg.sv
// Shared types and constants for the table interpolating linearizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tilu_pkg;

    // Field widths fixed by the item format.
    localparam int ADC_W    = 10;
    localparam int TEMP_W   = 16;
    localparam int IDX_W    = 5;
    localparam int CFG_W    = 6;
    localparam int STAT_W   = 2;

    // Interpolation datapath widths.
    localparam int DIFF_W   = TEMP_W + 1;
    localparam int DS_W     = ADC_W + 1;
    localparam int PROD_W   = DIFF_W + DS_W;
    localparam int MAG_W    = PROD_W - 2;
    localparam int DEN_W    = ADC_W;
    localparam int DCNT_W   = $clog2(MAG_W + 1);

    // Table defaults.
    localparam int               DEPTH_DEFAULT = 32;
    localparam logic [CFG_W-1:0] CFG_RESET     = 6'd32;
    localparam logic [CFG_W-1:0] CFG_MIN       = 6'd2;

    // Operation codes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Range status codes.
    localparam logic [STAT_W-1:0] ST_WITHIN = 2'd0;
    localparam logic [STAT_W-1:0] ST_BELOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABOVE  = 2'd2;

    // One breakpoint as stored in the table memory.
    typedef struct packed {
        logic [ADC_W-1:0]  adc;
        logic [TEMP_W-1:0] temp;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/tilu_table.sv
// Breakpoint table memory: one write port, one synchronous read port.
// Depends on tilu_pkg for the entry type.
`default_nettype none

module tilu_table
    import tilu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port: data for an enabled read appears in the next cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/tilu_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tilu_pkg for the datapath widths.
`default_nettype none

module tilu_div
    import tilu_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [MAG_W-1:0]      quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    // One shift-and-subtract step.
    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(MAG_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_next = DEN_W'(trial);
            end
            quo_next = {quo_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/table_interpolating_linearizer_unit.sv
// Top level of the table interpolating linearizer: sequencer, table, divider.
// Depends on tilu_pkg, tilu_table, tilu_div and the assertion macro header.
//
//  Channel | Ports                                   | Direction | Beat
//  --------+-----------------------------------------+-----------+-----------------------------
//  s_      | s_valid/s_ready, opcode, index, fields  | in        | load or convert item
//  m_      | m_valid/m_ready, temperature, status    | out       | one result per convert
//  cfg_    | cfg_wr_en, cfg_wr_data                  | in        | entries_in_use write
//
// A load beat writes the table at the accept edge.
// A convert beat scans the entries in use (at least two, at most the table depth),
// one table read per cycle through the memory's single read port, then a
// multiply step and the divider.
// Exact hits and clamped samples skip the multiply and divide.
// Reset is synchronous and active low; the table contents are not cleared.
// The input is held off while a convert is in flight or its result waits
// for the output register; loads are accepted even while m_valid is pending.
`default_nettype none
`include "table_interpolating_linearizer_unit_assert.svh"

module table_interpolating_linearizer_unit
    import tilu_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_opcode,
    input  wire logic [IDX_W-1:0]         s_entry_index,
    input  wire logic [ADC_W-1:0]         s_entry_adc,
    input  wire logic signed [TEMP_W-1:0] s_entry_temp,
    input  wire logic [ADC_W-1:0]         s_sample,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [TEMP_W-1:0]      m_temperature,
    output logic [STAT_W-1:0]             m_range_status,
    output logic                          m_exact_hit,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_W-1:0]         cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIVST = 3'd3;
    localparam logic [2:0] S_DIVW  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CFG_W-1:0]         cfg_reg, cfg_next;
    logic [ADC_W-1:0]         sample_reg, sample_next;
    logic [AW-1:0]            last_reg, last_next;
    logic [AW-1:0]            issue_idx_reg, issue_idx_next;
    logic                     issue_done_reg, issue_done_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [AW-1:0]            cmp_idx_reg, cmp_idx_next;
    entry_t                   prev_reg, prev_next;
    entry_t                   cur_reg, cur_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [TEMP_W-1:0]        res_temp_reg, res_temp_next;
    logic [STAT_W-1:0]        res_status_reg, res_status_next;
    logic                     res_exact_reg, res_exact_next;
    logic                     m_valid_reg, m_valid_next;
    logic [TEMP_W-1:0]        m_temp_reg, m_temp_next;
    logic [STAT_W-1:0]        m_status_reg, m_status_next;
    logic                     m_exact_reg, m_exact_next;

    logic                     s_fire;
    logic                     mem_we;
    logic                     mem_re;
    entry_t                   mem_wdata;
    entry_t                   mem_rdata;
    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic [MAG_W-1:0]         div_quo;
    logic [MAG_W-1:0]         div_mag;
    logic [DEN_W-1:0]         div_den;
    logic signed [PROD_W-1:0] diff_ext;
    logic signed [PROD_W-1:0] ds_ext;
    logic [TEMP_W-1:0]        q_lo;
    logic [TEMP_W-1:0]        q_adj;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // Table writes from load beats; indexes past the table are dropped.
    assign mem_we    = s_fire && (s_opcode == OP_LOAD) && (32'(s_entry_index) < TABLE_DEPTH);
    assign mem_wdata = '{adc: s_entry_adc, temp: s_entry_temp};
    assign mem_re    = (state_reg == S_SCAN) && !issue_done_reg;

    tilu_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (AW'(s_entry_index)),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (issue_idx_reg),
        .rd_data (mem_rdata)
    );

    // Interpolation operands from the bracketing pair.
    assign diff_ext = PROD_W'($signed({cur_reg.temp[TEMP_W-1], cur_reg.temp}))
                    - PROD_W'($signed({prev_reg.temp[TEMP_W-1], prev_reg.temp}));
    assign ds_ext   = PROD_W'($signed({1'b0, sample_reg - prev_reg.adc}));
    assign div_den  = cur_reg.adc - prev_reg.adc;
    assign div_mag  = prod_reg[PROD_W-1] ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);
    assign div_start = (state_reg == S_DIVST);

    tilu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Quotient rounded toward zero: negate the magnitude for a negative product.
    assign q_lo  = div_quo[TEMP_W-1:0];
    assign q_adj = prod_reg[PROD_W-1] ? (~q_lo + 1'b1) : q_lo;

    // Sequencer and datapath next state.
    always_comb begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        sample_next     = sample_reg;
        last_next       = last_reg;
        issue_idx_next  = issue_idx_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        prod_next       = prod_reg;
        res_temp_next   = res_temp_reg;
        res_status_next = res_status_reg;
        res_exact_next  = res_exact_reg;
        m_valid_next    = m_valid_reg;
        m_temp_next     = m_temp_reg;
        m_status_next   = m_status_reg;
        m_exact_next    = m_exact_reg;

        if (cfg_wr_en) begin
            cfg_next = cfg_wr_data;
        end

        // The output register empties when its beat is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_opcode == OP_CONVERT)) begin
                    sample_next     = s_sample;
                    issue_idx_next  = '0;
                    issue_done_next = 1'b0;
                    cmp_idx_next    = '0;
                    // Entry count saturated into the table's range.
                    if (32'(cfg_reg) > TABLE_DEPTH) begin
                        last_next = AW'(TABLE_DEPTH - 1);
                    end else if (cfg_reg < CFG_MIN) begin
                        last_next = AW'(1);
                    end else begin
                        last_next = AW'(cfg_reg - 1'b1);
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue side: one read a cycle up to the last entry in use.
                if (mem_re) begin
                    rd_valid_next = 1'b1;
                    if (issue_idx_reg == last_reg) begin
                        issue_done_next = 1'b1;
                    end else begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                // Compare side: data returned for entry cmp_idx_reg.
                if (rd_valid_reg) begin
                    if (mem_rdata.adc >= sample_reg) begin
                        cur_next      = mem_rdata;
                        res_temp_next = mem_rdata.temp;
                        if (mem_rdata.adc == sample_reg) begin
                            res_status_next = ST_WITHIN;
                            res_exact_next  = 1'b1;
                            state_next      = S_FIN;
                        end else if (cmp_idx_reg == '0) begin
                            res_status_next = ST_BELOW;
                            res_exact_next  = 1'b0;
                            state_next      = S_FIN;
                        end else begin
                            res_status_next = ST_WITHIN;
                            res_exact_next  = 1'b0;
                            state_next      = S_MUL;
                        end
                    end else if (cmp_idx_reg == last_reg) begin
                        res_temp_next   = mem_rdata.temp;
                        res_status_next = ST_ABOVE;
                        res_exact_next  = 1'b0;
                        state_next      = S_FIN;
                    end else begin
                        prev_next    = mem_rdata;
                        cmp_idx_next = cmp_idx_reg + 1'b1;
                    end
                end
            end
            S_MUL: begin
                prod_next  = diff_ext * ds_ext;
                state_next = S_DIVST;
            end
            S_DIVST: begin
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    res_temp_next = prev_reg.temp + q_adj;
                    state_next    = S_FIN;
                end
            end
            S_FIN: begin
                // Hand over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_temp_next   = res_temp_reg;
                    m_status_next = res_status_reg;
                    m_exact_next  = res_exact_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cfg_reg        <= CFG_RESET;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        last_reg       <= last_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        prod_reg       <= prod_next;
        res_temp_reg   <= res_temp_next;
        res_status_reg <= res_status_next;
        res_exact_reg  <= res_exact_next;
        m_temp_reg     <= m_temp_next;
        m_status_reg   <= m_status_next;
        m_exact_reg    <= m_exact_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_temperature  = m_temp_reg;
    assign m_range_status = m_status_reg;
    assign m_exact_hit    = m_exact_reg;

    // Read data only ever comes back in the cycle after a scan cycle.
    `TILU_ASSERT_NEXT(a_rd_in_scan, aclk, aresetn, state_reg != S_SCAN, !rd_valid_reg, "stray read data")
    // The divider only runs while the sequencer waits for it.
    `TILU_ASSERT_NOW(a_div_owned, aclk, aresetn, div_busy, state_reg == S_DIVW, "divider busy outside its wait state")
    // An exact hit is never reported together with a clamp.
    `TILU_ASSERT_NOW(a_exact_within, aclk, aresetn, m_valid && m_exact_hit, m_range_status == ST_WITHIN, "exact hit with clamp status")
    // An accepted convert beat starts the table scan.
    `TILU_ASSERT_NEXT(a_conv_scans, aclk, aresetn, s_valid && s_ready && (s_opcode == OP_CONVERT), state_reg == S_SCAN, "convert beat did not start scan")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for table_interpolating_linearizer_unit.
// Drives load and convert beats, predicts each untyped conversion from its own copy
// of the breakpoint table, and checks results in order. Depends on tilu_pkg.
`timescale 1ns / 100ps

module tb_top;
    import tilu_pkg::*;

    localparam int DEPTH           = DEPTH_DEFAULT;
    localparam int N_DIRECTED      = 17;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int SETTLE_CYCLES   = 100;
    localparam int MAX_SHOWN       = 10;
    localparam int TIMEOUT_NS      = 10_000_000;

    // One result as the block should present it.
    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic [STAT_W-1:0] status;
        logic              exact;
    } reading_t;

    // A conversion waiting for its result beat.
    typedef struct packed {
        logic [ADC_W-1:0] sample;
        reading_t         want;
    } conversion_t;

    // One input beat; typed rows carry their result written out by hand.
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [ADC_W-1:0]  adc;
        logic [TEMP_W-1:0] temp;
        logic [ADC_W-1:0]  sample;
        logic              typed;
        reading_t          want;
    } beat_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_opcode;
    logic [IDX_W-1:0]          s_entry_index;
    logic [ADC_W-1:0]          s_entry_adc;
    logic signed [TEMP_W-1:0]  s_entry_temp;
    logic [ADC_W-1:0]          s_sample;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [TEMP_W-1:0]  m_temperature;
    logic [STAT_W-1:0]         m_range_status;
    logic                      m_exact_hit;
    logic                      cfg_wr_en;
    logic [CFG_W-1:0]          cfg_wr_data;

    // Shadow copy of the table and the entry count.
    logic [ADC_W-1:0]          shadow_adc [DEPTH];
    logic signed [TEMP_W-1:0]  shadow_temp [DEPTH];
    logic [CFG_W-1:0]          shadow_entries;

    conversion_t               pending_conversions [$];
    beat_t                     directed_rows [N_DIRECTED];
    int                        fail_count;
    bit                        tx_idle;
    bit                        rx_idle;

    table_interpolating_linearizer_unit #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_entry_index  (s_entry_index),
        .s_entry_adc    (s_entry_adc),
        .s_entry_temp   (s_entry_temp),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_temperature  (m_temperature),
        .m_range_status (m_range_status),
        .m_exact_hit    (m_exact_hit),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    // Clock and the single reset pulse.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

    // Number of breakpoints the search covers, saturated into range.
    function automatic int active_entries();
        int n;
        n = shadow_entries;
        if (n > DEPTH)
            n = DEPTH;
        if (n < 2)
            n = 2;
        return n;
    endfunction

    // First-not-below search, then exact, clamped or interpolated value.
    function automatic reading_t interpolate_sample(logic [ADC_W-1:0] s);
        int       n;
        int       hit;
        longint   t0;
        longint   t1;
        longint   a0;
        longint   a1;
        longint   num;
        reading_t r;
        n   = active_entries();
        hit = -1;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && shadow_adc[i] >= s)
                hit = i;
        end
        r.status = ST_WITHIN;
        r.exact  = 1'b0;
        if (hit < 0) begin
            r.temperature = shadow_temp[n-1];
            r.status      = ST_ABOVE;
        end else if (shadow_adc[hit] == s) begin
            r.temperature = shadow_temp[hit];
            r.exact       = 1'b1;
        end else if (hit == 0) begin
            r.temperature = shadow_temp[0];
            r.status      = ST_BELOW;
        end else begin
            t0  = shadow_temp[hit-1];
            t1  = shadow_temp[hit];
            a0  = shadow_adc[hit-1];
            a1  = shadow_adc[hit];
            num = (t1 - t0) * (longint'(s) - a0);
            r.temperature = TEMP_W'(t0 + num / (a1 - a0));
        end
        return r;
    endfunction

    // Mirror an accepted beat: loads update the table, converts queue a result.
    task automatic record_beat(beat_t b);
        conversion_t c;
        if (b.op == OP_LOAD) begin
            shadow_adc[b.idx]  = b.adc;
            shadow_temp[b.idx] = b.temp;
        end else begin
            c.sample = b.sample;
            c.want   = b.typed ? b.want : interpolate_sample(b.sample);
            pending_conversions.push_back(c);
        end
    endtask

    // Present one beat, after a random gap while tx_idle is set, and hold it until accepted.
    task automatic send_beat(beat_t b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode      = b.op;
        s_entry_index = b.idx;
        s_entry_adc   = b.adc;
        s_entry_temp  = b.temp;
        s_sample      = b.sample;
        s_valid       = 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        record_beat(b);
    endtask

    // Drop valid and wait until every conversion has returned, then settle.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_conversions.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the entry count while the block is idle.
    task automatic set_entries(logic [CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en      = 1'b0;
        shadow_entries = value;
    endtask

    // Random filler for fields the operation does not use.
    function automatic beat_t load_beat(int idx, int adc, logic [TEMP_W-1:0] temp);
        beat_t b;
        b.op     = OP_LOAD;
        b.idx    = IDX_W'(idx);
        b.adc    = ADC_W'(adc);
        b.temp   = temp;
        b.sample = ADC_W'($urandom);
        b.typed  = 1'b0;
        b.want   = '0;
        return b;
    endfunction

    function automatic beat_t convert_beat(int s);
        beat_t b;
        b.op     = OP_CONVERT;
        b.idx    = IDX_W'($urandom);
        b.adc    = ADC_W'($urandom);
        b.temp   = TEMP_W'($urandom);
        b.sample = ADC_W'(s);
        b.typed  = 1'b0;
        b.want   = '0;
        return b;
    endfunction

    // Fill the whole table with ascending breakpoints spread over the active count.
    task automatic load_ascending_table();
        int a;
        int stride;
        stride = 1000 / active_entries();
        a = $urandom_range(0, 40);
        for (int i = 0; i < DEPTH; i++) begin
            send_beat(load_beat(i, a, TEMP_W'($urandom)));
            a = a + $urandom_range(0, stride);
            if (a > 1023)
                a = 1023;
        end
    endtask

    // Random beat: mostly conversions aimed at the active span, some stray loads.
    function automatic beat_t random_beat();
        int roll;
        int n;
        int lo;
        int hi;
        roll = $urandom_range(0, 99);
        n    = active_entries();
        lo   = shadow_adc[0];
        hi   = shadow_adc[n-1];
        if (roll < 12)
            return load_beat($urandom_range(0, DEPTH - 1), $urandom_range(0, 1023),
                             TEMP_W'($urandom));
        if (roll < 50 && lo < hi)
            return convert_beat($urandom_range(lo, hi));
        if (roll < 70)
            return convert_beat(shadow_adc[$urandom_range(0, n - 1)]);
        return convert_beat($urandom_range(0, 1023));
    endfunction

    // Result checker: compare each result beat with the oldest expectation.
    always @(posedge aclk) begin : result_check
        conversion_t c;
        if (aresetn && m_valid && m_ready) begin
            if (pending_conversions.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected result beat: temp %0d status %0d exact %0d",
                             m_temperature, m_range_status, m_exact_hit);
            end else begin
                c = pending_conversions.pop_front();
                if (m_temperature !== c.want.temperature || m_range_status !== c.want.status ||
                    m_exact_hit !== c.want.exact) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("mismatch for sample %0d: expected temp %0d status %0d exact %0d, got temp %0d status %0d exact %0d",
                                 c.sample, $signed(c.want.temperature), c.want.status,
                                 c.want.exact, m_temperature, m_range_status, m_exact_hit);
                end
            end
        end
    end

    // Result side: random stall before each beat while rx_idle is set.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            repeat (gap) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do
                @(posedge aclk);
            while (!(m_valid && m_ready));
        end
    end

    // Stimulus: preload, directed rows, then phases of random traffic.
    initial begin
        logic [CFG_W-1:0] entry_plan [N_PHASES];
        s_valid        = 1'b0;
        s_opcode       = OP_LOAD;
        s_entry_index  = '0;
        s_entry_adc    = '0;
        s_entry_temp   = '0;
        s_sample       = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        fail_count     = 0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        shadow_entries = CFG_RESET;
        entry_plan     = '{6'd2, 6'd32, 6'd0, 6'd1, 6'd33, 6'd63,
                           CFG_W'($urandom), CFG_W'($urandom)};

        // Hand-checked rows run on the preloaded table with the reset count.
        // Temperatures -400 and 1150 are the first and last preload entries.
        directed_rows = '{
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd0, 1'b1, '{-16'sd400, ST_BELOW, 1'b0}},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd16, 1'b1, '{-16'sd400, ST_WITHIN, 1'b1}},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd1023, 1'b1, '{16'sd1150, ST_ABOVE, 1'b0}},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd1008, 1'b1, '{16'sd1150, ST_WITHIN, 1'b1}},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd20, 1'b0, '0},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd500, 1'b0, '0},
            // Most negative temperature at ADC zero.
            '{OP_LOAD, 5'd0, 10'd0, 16'h8000, 10'd0, 1'b0, '0},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd0, 1'b1, '{16'h8000, ST_WITHIN, 1'b1}},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd1, 1'b0, '0},
            // Most positive temperature at full scale.
            '{OP_LOAD, 5'd31, 10'd1023, 16'h7FFF, 10'd0, 1'b0, '0},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd1023, 1'b1, '{16'h7FFF, ST_WITHIN, 1'b1}},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd1022, 1'b0, '0},
            // Break the ordering so the previous entry sits far below.
            '{OP_LOAD, 5'd30, 10'd1, 16'h7FFF, 10'd0, 1'b0, '0},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd1022, 1'b0, '0},
            // Full-scale span from the minimum to the maximum temperature.
            '{OP_LOAD, 5'd1, 10'd1023, 16'h7FFF, 10'd0, 1'b0, '0},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd512, 1'b0, '0},
            '{OP_CONVERT, 5'd0, 10'd0, 16'd0, 10'd1023, 1'b1, '{16'h7FFF, ST_WITHIN, 1'b1}}
        };

        @(posedge aresetn);

        // Every entry is written before the first conversion reads the table.
        for (int i = 0; i < DEPTH; i++)
            send_beat(load_beat(i, 32 * i + 16, TEMP_W'(-400 + 50 * i)));
        for (int i = 0; i < N_DIRECTED; i++)
            send_beat(directed_rows[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            set_entries(entry_plan[p]);
            tx_idle = (p != 2);
            rx_idle = (p != 3);
            load_ascending_table();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Now and then hold off until the result side has caught up.
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                send_beat(random_beat());
            end
        end

        wait_drained();
        if (fail_count == 0 && pending_conversions.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
